// ===== design/sup_pkg.sv =====
// Shared types and constants for the series upsampler (linear / step).
// Used by the front end, the request queue, the back end and the top level.
// No dependencies.
package sup_pkg;

   localparam int VALUE_W     = 48;
   localparam int RATIO_W     = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int QUEUE_DEPTH = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_METHOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KIND   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO  = 2'd2;

   localparam logic METHOD_LINEAR = 1'b0;
   localparam logic KIND_STOCK    = 1'b0;
   localparam logic KIND_FLOW     = 1'b1;

   localparam logic [RATIO_W-1:0] RATIO_MIN = 7'd2;

   // What the back end does with one request.
   typedef enum logic [1:0] {
      OP_ZERO,
      OP_REPEAT,
      OP_DIVIDE,
      OP_INTERP
   } sup_op_type;

   typedef struct packed {
      sup_op_type         op;
      logic [VALUE_W-1:0] base;   // starting value (previous or current sample)
      logic [VALUE_W:0]   num;    // signed dividend: difference or current sample
      logic [RATIO_W-1:0] ratio;  // clamped sub-period count
   } sup_item_type;

endpackage

// ===== design/sup_front.sv =====
// Front end: configuration registers, previous-sample state and request classification.
// Depends on sup_pkg.
module sup_front #(
   parameter int MAX_RATIO = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sup_pkg::VALUE_W-1:0]   req_sample_value,
   input  logic                                 req_sample_valid,
   input  logic                                 req_first_of_series,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sup_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sup_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 queue_full,
   output logic                                 push,
   output sup_pkg::sup_item_type                push_item
);
   import sup_pkg::*;

   logic                     method_ff, method_in;
   logic                     kind_ff, kind_in;
   logic [RATIO_W-1:0]       ratio_ff, ratio_in;
   logic [VALUE_W-1:0]       prev_sample_ff, prev_sample_in;
   logic                     prev_valid_ff, prev_valid_in;
   logic [RATIO_W-1:0]       ratio_eff;
   logic [VALUE_W:0]         diff;
   logic                     interp;
   logic                     accept;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept;

   always_comb begin
      method_in = method_ff;
      kind_in   = kind_ff;
      ratio_in  = ratio_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_METHOD: method_in = csr_wdata[0];
            CSR_KIND:   kind_in   = csr_wdata[0];
            CSR_RATIO:  ratio_in  = csr_wdata[RATIO_W-1:0];
            default:    ;
         endcase
      end
   end

   assign prev_sample_in = accept ? req_sample_value : prev_sample_ff;
   assign prev_valid_in  = accept ? req_sample_valid : prev_valid_ff;

   always_comb begin
      ratio_eff = ratio_ff;
      if (ratio_ff < RATIO_MIN) begin
         ratio_eff = RATIO_MIN;
      end else if (ratio_ff > RATIO_W'(MAX_RATIO)) begin
         ratio_eff = RATIO_W'(MAX_RATIO);
      end

      interp = (method_ff == METHOD_LINEAR) && (kind_ff == KIND_STOCK);
      diff   = {req_sample_value[VALUE_W-1], req_sample_value}
               - {prev_sample_ff[VALUE_W-1], prev_sample_ff};

      push_item.ratio = ratio_eff;
      push_item.base  = req_sample_value;
      push_item.num   = {req_sample_value[VALUE_W-1], req_sample_value};
      push_item.op    = OP_ZERO;

      if (interp) begin
         // Interpolation runs from the previous sample toward the current one.
         push_item.base = prev_sample_ff;
         push_item.num  = diff;
         if (req_sample_valid && prev_valid_ff && !req_first_of_series) begin
            push_item.op = OP_INTERP;
         end
      end else if (req_sample_valid) begin
         push_item.op = (kind_ff == KIND_FLOW) ? OP_DIVIDE : OP_REPEAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff      <= METHOD_LINEAR;
         kind_ff        <= KIND_STOCK;
         ratio_ff       <= RATIO_W'(4);
         prev_sample_ff <= '0;
         prev_valid_ff  <= 1'b0;
      end else begin
         method_ff      <= method_in;
         kind_ff        <= kind_in;
         ratio_ff       <= ratio_in;
         prev_sample_ff <= prev_sample_in;
         prev_valid_ff  <= prev_valid_in;
      end
   end

endmodule

// ===== design/sup_queue.sv =====
// Short request queue between the front end and the back end.
// Depends on sup_pkg.
module sup_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sup_pkg::sup_item_type push_item,
   output logic                  full,
   output logic                  q_valid,
   output sup_pkg::sup_item_type q_item,
   input  logic                  pop
);
   import sup_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   sup_item_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/sup_back.sv =====
// Back end: bit-serial divider by the ratio (divide and interpolate only), then one sub-period
// result per cycle into the response register unless the output stalls. Depends on sup_pkg.
module sup_back #(
   parameter int MAX_RATIO = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  sup_pkg::sup_item_type              q_item,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [sup_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                               rsp_out_valid,
   output logic                               rsp_last_of_run
);
   import sup_pkg::*;

   localparam int RW  = $clog2(MAX_RATIO + 1);
   localparam int DCW = $clog2(VALUE_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   sup_op_type         op_ff, op_in;
   logic [VALUE_W-1:0] base_ff, base_in;
   logic               neg_ff, neg_in;
   logic [RW-1:0]      ratio_ff, ratio_in;
   logic [VALUE_W-1:0] quo_ff, quo_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic [DCW-1:0]     div_cnt_ff, div_cnt_in;
   logic [VALUE_W-1:0] step_ff, step_in;
   logic [VALUE_W-1:0] step1_ff, step1_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [RW-1:0]      frac_ff, frac_in;
   logic [RW-1:0]      cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_ovalid_ff, rsp_ovalid_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [RW:0]        trial;
   logic               trial_ge;
   logic [RW:0]        frac_sum;
   logic               carry;
   logic               out_free;
   logic               last;
   logic [VALUE_W-1:0] next_acc;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_valid   = rsp_ovalid_ff;
   assign rsp_last_of_run = rsp_last_ff;

   always_comb begin
      trial    = {rem_ff, quo_ff[VALUE_W-1]};
      trial_ge = (trial >= {1'b0, ratio_ff});
      // The fractional part of the running numerator grows by the remainder each
      // sub-period; once it reaches the ratio, the quotient steps one extra unit.
      frac_sum = {1'b0, frac_ff} + {1'b0, rem_ff};
      carry    = (frac_sum >= {1'b0, ratio_ff});
      next_acc = acc_ff + (carry ? step1_ff : step_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
      last     = (cnt_ff == RW'(ratio_ff - 1'b1));

      state_in      = state_ff;
      op_in         = op_ff;
      base_in       = base_ff;
      neg_in        = neg_ff;
      ratio_in      = ratio_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      step_in       = step_ff;
      step1_in      = step1_ff;
      acc_in        = acc_ff;
      frac_in       = frac_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_ovalid_in = rsp_ovalid_ff;
      rsp_last_in   = rsp_last_ff;
      pop           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop        = 1'b1;
               op_in      = q_item.op;
               base_in    = q_item.base;
               neg_in     = q_item.num[VALUE_W];
               ratio_in   = q_item.ratio[RW-1:0];
               quo_in     = q_item.num[VALUE_W] ? (~q_item.num[VALUE_W-1:0] + 1'b1)
                                                : q_item.num[VALUE_W-1:0];
               rem_in     = '0;
               div_cnt_in = DCW'(VALUE_W - 1);
               acc_in     = q_item.base;
               frac_in    = '0;
               cnt_in     = '0;
               state_in   = (q_item.op == OP_DIVIDE || q_item.op == OP_INTERP) ? ST_DIV
                                                                               : ST_EMIT;
            end
         end
         ST_DIV: begin
            rem_in     = trial_ge ? RW'(trial - {1'b0, ratio_ff}) : trial[RW-1:0];
            quo_in     = {quo_ff[VALUE_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // Signed quotient step, and the same step one unit larger in magnitude.
            step_in  = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
            step1_in = neg_ff ? ~quo_ff : (quo_ff + 1'b1);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last;
               cnt_in       = cnt_ff + 1'b1;
               unique case (op_ff)
                  OP_ZERO: begin
                     rsp_value_in  = '0;
                     rsp_ovalid_in = 1'b0;
                  end
                  OP_REPEAT: begin
                     rsp_value_in  = base_ff;
                     rsp_ovalid_in = 1'b1;
                  end
                  OP_DIVIDE: begin
                     rsp_value_in  = step_ff;
                     rsp_ovalid_in = 1'b1;
                  end
                  OP_INTERP: begin
                     rsp_value_in  = next_acc;
                     rsp_ovalid_in = 1'b1;
                     acc_in        = next_acc;
                     frac_in       = carry ? RW'(frac_sum - {1'b0, ratio_ff})
                                           : frac_sum[RW-1:0];
                  end
               endcase
               if (last) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      base_ff       <= base_in;
      neg_ff        <= neg_in;
      ratio_ff      <= ratio_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      step_ff       <= step_in;
      step1_ff      <= step1_in;
      acc_ff        <= acc_in;
      frac_ff       <= frac_in;
      cnt_ff        <= cnt_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_ovalid_ff <= rsp_ovalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// ===== design/series_upsampler_lin_step_top.sv =====
// Data path: a request is accepted into the request queue; the back end takes it when idle,
// runs divide and interpolate requests through the bit-serial divider and a prep step, and
// passes every result through the response register.
// Throughput: each request gives R results (R = clamped ratio), one result per cycle while
// the output is not stalled; the back end takes a new request only after its last result.
// Reset (synchronous, active high) restores linear stock mode with ratio 4, forgets the
// previous sample and empties the request queue.
module series_upsampler_lin_step_top #(
   parameter int MAX_RATIO = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [sup_pkg::VALUE_W-1:0] req_sample_value,
   input  logic                               req_sample_valid,
   input  logic                               req_first_of_series,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [sup_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                               rsp_out_valid,
   output logic                               rsp_last_of_run,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sup_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sup_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sup_pkg::*;

   logic         push;
   sup_item_type push_item;
   logic         queue_full;
   logic         q_valid;
   sup_item_type q_item;
   logic         pop;

   sup_front #(
      .MAX_RATIO (MAX_RATIO)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_value    (req_sample_value),
      .req_sample_valid    (req_sample_valid),
      .req_first_of_series (req_first_of_series),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .queue_full          (queue_full),
      .push                (push),
      .push_item           (push_item)
   );

   sup_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .pop       (pop)
   );

   sup_back #(
      .MAX_RATIO (MAX_RATIO)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for series_upsampler_lin_step_top: a directed table, then random
// phases with register changes, random idling on both sides and a long output hold-off.
// Depends on sup_pkg and the top level in design/.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sup_pkg::*;

   localparam int CLOCK_PERIOD     = 10;
   localparam int MAX_RATIO        = 64;
   localparam int RANDOM_ITEMS     = 445;
   localparam int DRAIN_CYCLES     = 4;
   localparam int END_CYCLES       = 60;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 3000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [VALUE_W-1:0]   V_MAX      = 48'h7FFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0]   V_MIN      = 48'h8000_0000_0000;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   // One line of the directed table. For sample rows with given set, every sub-period
   // is expected to carry exp_value and exp_valid; other sample rows go to the predictor.
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
      logic [VALUE_W-1:0]    value;
      logic                  sample_ok;
      logic                  first;
      logic                  given;
      logic [VALUE_W-1:0]    exp_value;
      logic                  exp_valid;
   } directed_row_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               valid;
      logic               last;
   } subperiod_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic signed [VALUE_W-1:0]         req_sample_value;
   logic                              req_sample_valid;
   logic                              req_first_of_series;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic signed [VALUE_W-1:0]         rsp_out_value;
   logic                              rsp_out_valid;
   logic                              rsp_last_of_run;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [CSR_IDX_W-1:0]              csr_index;
   logic [CSR_DATA_W-1:0]             csr_wdata;

   // Predictor copy of the registers and of the series state.
   logic                      cfg_method = 1'b0;
   logic                      cfg_kind   = 1'b0;
   logic [RATIO_W-1:0]        cfg_ratio  = 7'd4;
   logic signed [VALUE_W-1:0] prev_sample = '0;
   logic                      prev_valid  = 1'b0;

   subperiod_type expected_subperiods[$];
   int            failures = 0;
   int            stuck_cycles = 0;
   logic          idle_enable = 1'b1;
   logic          hold_off_pending = 1'b0;

   directed_row_type directed_rows [0:36] = '{
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'h0000_0005_0000, 1'b1, 1'b0, 1'b1, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'h0000_0007_0000, 1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   V_MAX,              1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   V_MIN,              1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'h0000_0003_0000, 1'b1, 1'b1, 1'b1, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'h0000_0000_3039, 1'b0, 1'b0, 1'b1, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'hFFFF_FFFF_FFFD, 1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_RATIO,  7'd0,   48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'h0000_0000_0064, 1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_RATIO,  7'd127, 48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'hFF00_0000_0007, 1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_RATIO,  7'd1,   48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   V_MIN,              1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_RATIO,  7'd65,  48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   V_MAX,              1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_UNUSED, 7'h7F,  48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_METHOD, 7'h7F,  48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   V_MAX,              1'b1, 1'b0, 1'b1, V_MAX, 1'b1},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   V_MIN,              1'b1, 1'b0, 1'b1, V_MIN, 1'b1},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'h0000_DEAD_BEEF, 1'b0, 1'b0, 1'b1, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'h0000_002A_0000, 1'b1, 1'b1, 1'b1,
        48'h0000_002A_0000, 1'b1},
      '{ROW_WRITE,  CSR_KIND,   7'h01,  48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_RATIO,  7'd3,   48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'hFFFF_FFFF_FFF9, 1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   V_MIN,              1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   V_MAX,              1'b0, 1'b0, 1'b1, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_METHOD, 7'h7E,  48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_RATIO,  7'd64,  48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   V_MAX,              1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'h0000_0005_0000, 1'b0, 1'b0, 1'b1, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_KIND,   7'h00,  48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_WRITE,  CSR_RATIO,  7'd2,   48'd0,              1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'h0000_0000_0001, 1'b1, 1'b0, 1'b1, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 48'd0, 1'b0},
      '{ROW_SAMPLE, CSR_METHOD, 7'd0,   48'h0000_0000_0000, 1'b1, 1'b0, 1'b0, 48'd0, 1'b0}
   };

   series_upsampler_lin_step_top #(
      .MAX_RATIO (MAX_RATIO)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_value    (req_sample_value),
      .req_sample_valid    (req_sample_valid),
      .req_first_of_series (req_first_of_series),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_value       (rsp_out_value),
      .rsp_out_valid       (rsp_out_valid),
      .rsp_last_of_run     (rsp_last_of_run),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int effective_ratio();
      if (cfg_ratio < RATIO_MIN) return int'(RATIO_MIN);
      if (cfg_ratio > MAX_RATIO) return MAX_RATIO;
      return int'(cfg_ratio);
   endfunction

   // Appends one sub-period to the tail of the expected list.
   function automatic void add_expected(input subperiod_type sp);
      expected_subperiods = {expected_subperiods, sp};
   endfunction

   // Sub-period values for one low-rate sample under the current register settings.
   function automatic void predict_subperiods(input logic signed [VALUE_W-1:0] sample,
                                              input logic sample_ok, input logic first);
      longint        cur;
      longint        prev;
      longint        v;
      int            count;
      int            j;
      logic          interp;
      logic          ok;
      subperiod_type sp;
      cur    = sample;
      prev   = prev_sample;
      count  = effective_ratio();
      interp = (cfg_method == METHOD_LINEAR) && (cfg_kind == KIND_STOCK);
      ok     = interp ? (sample_ok && prev_valid && !first) : sample_ok;
      for (j = 0; j < count; j++) begin
         v = 0;
         if (ok) begin
            if (interp) v = prev + ((cur - prev) * (j + 1)) / count;
            else if (cfg_kind == KIND_FLOW) v = cur / count;
            else v = cur;
         end
         sp.value = v[VALUE_W-1:0];
         sp.valid = ok;
         sp.last  = (j == count - 1);
         add_expected(sp);
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input logic signed [VALUE_W-1:0] value, input logic sample_ok,
                               input logic first, input logic given,
                               input logic [VALUE_W-1:0] exp_value, input logic exp_valid);
      int            count;
      int            j;
      subperiod_type sp;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_sample_value    <= value;
      req_sample_valid    <= sample_ok;
      req_first_of_series <= first;
      do @(posedge clock); while (req_stall);
      if (given) begin
         count = effective_ratio();
         for (j = 0; j < count; j++) begin
            sp.value = exp_value;
            sp.valid = exp_valid;
            sp.last  = (j == count - 1);
            add_expected(sp);
         end
      end else begin
         predict_subperiods(value, sample_ok, first);
      end
      prev_sample = value;
      prev_valid  = sample_ok;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_subperiods.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Registers change only with the block idle, so every write drains first.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_METHOD: cfg_method = data[0];
         CSR_KIND:   cfg_kind   = data[0];
         CSR_RATIO:  cfg_ratio  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Output side: random stall bursts, plus one long hold-off when asked for.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      subperiod_type exp_sp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_subperiods.size() == 0) begin
            $error("unexpected result: out_value %0d out_valid %0b last_of_run %0b",
                   rsp_out_value, rsp_out_valid, rsp_last_of_run);
            failures++;
         end else begin
            exp_sp = expected_subperiods.pop_front();
            if (rsp_out_value !== exp_sp.value) begin
               $error("out_value: expected %0d, got %0d", $signed(exp_sp.value),
                      rsp_out_value);
               failures++;
            end
            if (rsp_out_valid !== exp_sp.valid) begin
               $error("out_valid: expected %0b, got %0b", exp_sp.valid, rsp_out_valid);
               failures++;
            end
            if (rsp_last_of_run !== exp_sp.last) begin
               $error("last_of_run: expected %0b, got %0b", exp_sp.last, rsp_last_of_run);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      logic signed [VALUE_W-1:0] value;
      logic [63:0]               bits64;
      logic                      sample_ok;
      logic                      first;
      logic [RATIO_W-1:0]        ratio_w;
      int                        small_off;
      int                        sent;
      int                        phase;
      int                        phase_len;
      int                        k;

      reset               = 1'b1;
      req_valid           = 1'b0;
      req_sample_value    = '0;
      req_sample_valid    = 1'b0;
      req_first_of_series = 1'b0;
      csr_valid           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE)
            write_register(directed_rows[i].index, directed_rows[i].wdata);
         else
            send_request(directed_rows[i].value, directed_rows[i].sample_ok,
                         directed_rows[i].first, directed_rows[i].given,
                         directed_rows[i].exp_value, directed_rows[i].exp_valid);
      end

      // Random phases: new settings with the block idle, then a series of samples.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         write_register(CSR_METHOD, 7'($urandom_range(0, 127)));
         write_register(CSR_KIND, 7'($urandom_range(0, 127)));
         case ($urandom_range(0, 9))
            0:       ratio_w = 7'($urandom_range(0, 1));
            1:       ratio_w = 7'($urandom_range(65, 127));
            2:       ratio_w = 7'($urandom_range(9, 64));
            3:       ratio_w = 7'd64;
            default: ratio_w = 7'($urandom_range(2, 8));
         endcase
         write_register(CSR_RATIO, ratio_w);
         if ($urandom_range(0, 3) == 0) write_register(CSR_UNUSED, 7'($urandom_range(0, 127)));
         // In the third phase the output is held off while requests keep coming.
         if (phase == 2) hold_off_pending = 1'b1;
         if (sent > RANDOM_ITEMS - 60) idle_enable = 1'b0;
         phase_len = $urandom_range(10, 30);
         for (k = 0; k < phase_len; k++) begin
            case ($urandom_range(0, 7))
               0, 1: begin
                  bits64 = {$urandom(), $urandom()};
                  value  = bits64[VALUE_W-1:0];
               end
               2: value = ($urandom_range(0, 1) == 0) ? V_MAX : V_MIN;
               3: begin
                  small_off = $urandom_range(0, 2000);
                  value     = VALUE_W'(small_off - 1000);
               end
               4: begin
                  small_off = $urandom_range(0, 2);
                  value     = VALUE_W'(small_off - 1);
               end
               default: value = $signed($urandom());
            endcase
            sample_ok = ($urandom_range(0, 9) != 0);
            first     = (k == 0) || ($urandom_range(0, 24) == 0);
            send_request(value, sample_ok, first, 1'b0, '0, 1'b0);
            sent++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (expected_subperiods.size() != 0) @(negedge clock);
      repeat (END_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
